/* rtl/core/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// stbs_pkg
// shared types and constants of the sorted table search block
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int COUNT_W = 11;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 10;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_MATCH_MODE  = 1'b1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [MODE_W-1:0] MODE_ANY_EQ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST_EQ = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIRST_GT = 2'd2;

    typedef struct packed {
        logic take_best;
        logic go_left;
        logic stop;
    } step_ctl_t;

endpackage

/* rtl/core/stbs_table.sv */
// ----------------------------------------------------------------------------
// stbs_table
// simple dual-port table memory (one write, one read port) with registered read data
// ----------------------------------------------------------------------------
module stbs_table #(
    parameter int DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(stbs_pkg::TABLE_DEPTH_DEF)
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [AW-1:0]                           wr_addr,
    input  logic signed [stbs_pkg::VALUE_W-1:0]     wr_data,
    input  logic                                    rd_en,
    input  logic [AW-1:0]                           rd_addr,
    output logic signed [stbs_pkg::VALUE_W-1:0]     rd_data
);

    logic signed [stbs_pkg::VALUE_W-1:0] mem [DEPTH];
    logic signed [stbs_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/stbs_step.sv */
// ----------------------------------------------------------------------------
// stbs_step
// compare unit: probed entry against key, decides bound move per mode
// ----------------------------------------------------------------------------
module stbs_step (
    input  logic signed [stbs_pkg::VALUE_W-1:0] probe_value,
    input  logic signed [stbs_pkg::VALUE_W-1:0] key,
    input  logic [stbs_pkg::MODE_W-1:0]         mode,
    output stbs_pkg::step_ctl_t                 ctl
);

    logic eq;
    logic gt;

    assign eq = (probe_value == key);
    assign gt = (probe_value > key);

    always_comb
    begin
        if (mode == stbs_pkg::MODE_FIRST_GT)
        begin
            ctl.take_best = gt;
            ctl.go_left   = gt;
            ctl.stop      = 1'b0;
        end
        else
        begin
            ctl.take_best = eq;
            ctl.go_left   = eq | gt;
            ctl.stop      = eq & (mode == stbs_pkg::MODE_ANY_EQ);
        end
    end

endmodule

/* rtl/core/sorted_table_binary_search_top.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// sorted table with lower / upper bound binary search
// ----------------------------------------------------------------------------
// requests come in on req_valid / req_ready; cmd selects a table write or a
// search query. a write stores entry_value at entry_index and gives no result.
// a query searches the first entry_count entries (capped at the table depth)
// and gives one result (found, position) on res_valid / res_ready. entry_count
// and match_mode are to be set over the apb port only while the block is idle;
// the block itself does not enforce this. each probe reads the table, then
// compares and updates the bounds; when they meet, the done state loads the
// result. in any-equal mode an exact-match hit ends the search at that probe.
// req_ready is high only while the sequencer is idle; one request at a time.
// a finished result waits in the output register; while an earlier result is
// held and res_ready is low the sequencer holds in its done state and takes no
// new request. reset clears the config registers, the sequencer and the result
// valid; table contents are undefined until written and need no clearing.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [stbs_pkg::ADDR_W-1:0]             paddr,
    input  logic [stbs_pkg::DATA_W-1:0]             pwdata,
    output logic [stbs_pkg::DATA_W-1:0]             prdata,
    output logic                                    pready,
    input  logic                                    req_valid,
    output logic                                    req_ready,
    input  logic                                    cmd,
    input  logic [stbs_pkg::INDEX_W-1:0]            entry_index,
    input  logic signed [stbs_pkg::VALUE_W-1:0]     entry_value,
    input  logic signed [stbs_pkg::VALUE_W-1:0]     search_key,
    output logic                                    res_valid,
    input  logic                                    res_ready,
    output logic                                    found,
    output logic [stbs_pkg::POS_W-1:0]              position
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (NW > stbs_pkg::COUNT_W) ? NW : stbs_pkg::COUNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [stbs_pkg::COUNT_W-1:0]         entry_count_reg, entry_count_next;
    logic [stbs_pkg::MODE_W-1:0]          match_mode_reg, match_mode_next;
    logic [1:0]                           state_reg, state_next;
    logic signed [stbs_pkg::VALUE_W-1:0]  key_reg, key_next;
    logic [NW-1:0]                        lo_reg, lo_next;
    logic [NW-1:0]                        hi_reg, hi_next;
    logic [AW-1:0]                        mid_reg, mid_next;
    logic [AW-1:0]                        best_reg, best_next;
    logic                                 best_valid_reg, best_valid_next;
    logic                                 res_valid_reg, res_valid_next;
    logic                                 found_reg, found_next;
    logic [stbs_pkg::POS_W-1:0]           position_reg, position_next;

    logic                                 cfg_wr;
    logic                                 req_fire;
    logic                                 tbl_wr_en;
    logic                                 tbl_rd_en;
    logic signed [stbs_pkg::VALUE_W-1:0]  tbl_rd_data;
    logic [NW-1:0]                        mid_calc;
    logic [CW-1:0]                        count_ext;
    logic [CW-1:0]                        count_sat;
    logic                                 res_load;
    stbs_pkg::step_ctl_t                  step_ctl;

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        entry_count_next = entry_count_reg;
        match_mode_next  = match_mode_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == stbs_pkg::REG_ENTRY_COUNT)
            begin
                entry_count_next = pwdata[stbs_pkg::COUNT_W-1:0];
            end
            else
            begin
                match_mode_next = pwdata[stbs_pkg::MODE_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == stbs_pkg::REG_ENTRY_COUNT) ?
                    stbs_pkg::DATA_W'(entry_count_reg) :
                    stbs_pkg::DATA_W'(match_mode_reg);

    // request side
    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid & req_ready;
    assign tbl_wr_en = req_fire & (cmd == stbs_pkg::CMD_WRITE) &
                       (32'(entry_index) < 32'(TABLE_DEPTH));

    assign count_ext = CW'(entry_count_reg);
    assign count_sat = (count_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : count_ext;

    assign mid_calc  = lo_reg + ((hi_reg - lo_reg - NW'(1)) >> 1);
    assign tbl_rd_en = (state_reg == ST_PROBE) & (lo_reg < hi_reg);
    assign res_load  = (state_reg == ST_DONE) & (~res_valid_reg | res_ready);

    stbs_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (AW'(entry_index)),
        .wr_data (entry_value),
        .rd_en   (tbl_rd_en),
        .rd_addr (AW'(mid_calc)),
        .rd_data (tbl_rd_data)
    );

    stbs_step u_step (
        .probe_value (tbl_rd_data),
        .key         (key_reg),
        .mode        (match_mode_reg),
        .ctl         (step_ctl)
    );

    // search sequencer
    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        best_next       = best_reg;
        best_valid_next = best_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (cmd == stbs_pkg::CMD_QUERY))
                begin
                    key_next        = search_key;
                    lo_next         = '0;
                    hi_next         = NW'(count_sat);
                    best_valid_next = 1'b0;
                    best_next       = '0;
                    if ((match_mode_reg == stbs_pkg::MODE_ANY_EQ) ||
                        (match_mode_reg == stbs_pkg::MODE_FIRST_EQ) ||
                        (match_mode_reg == stbs_pkg::MODE_FIRST_GT))
                    begin
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = AW'(mid_calc);
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP:
            begin
                if (step_ctl.take_best)
                begin
                    best_next       = mid_reg;
                    best_valid_next = 1'b1;
                end
                if (step_ctl.stop)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    if (step_ctl.go_left)
                    begin
                        hi_next = NW'(mid_reg);
                    end
                    else
                    begin
                        lo_next = NW'(mid_reg) + NW'(1);
                    end
                    state_next = ST_PROBE;
                end
            end
            ST_DONE:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        found_next     = found_reg;
        position_next  = position_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
            found_next     = best_valid_reg;
            position_next  = best_valid_reg ? stbs_pkg::POS_W'(best_reg) : '0;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            match_mode_reg  <= stbs_pkg::MODE_ANY_EQ;
            state_reg       <= ST_IDLE;
            best_valid_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            match_mode_reg  <= match_mode_next;
            state_reg       <= state_next;
            best_valid_reg  <= best_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        best_reg     <= best_next;
        found_reg    <= found_next;
        position_reg <= position_next;
    end

    // checks
    a_probe_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> ((NW'(mid_reg) >= lo_reg) && (NW'(mid_reg) < hi_reg)))
        else $error("probe index outside search bounds");

    a_write_no_search: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (cmd == stbs_pkg::CMD_WRITE)) |=> (state_reg == ST_IDLE))
        else $error("table write started a search");

    a_miss_position_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !found) |-> (position == '0))
        else $error("miss result with nonzero position");

    a_bad_mode_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (cmd == stbs_pkg::CMD_QUERY) && (match_mode_reg != stbs_pkg::MODE_ANY_EQ)
         && (match_mode_reg != stbs_pkg::MODE_FIRST_EQ)
         && (match_mode_reg != stbs_pkg::MODE_FIRST_GT)) |=> (state_reg == ST_DONE))
        else $error("unused mode did not skip the search");

endmodule
